// ----- src/tsm_pkg.sv -----
package tsm_pkg;

  localparam int COORD_W = 24;
  localparam int CFG_W   = 32;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int DOT_W   = PROD_W + 1;
  localparam int DEN_W   = DOT_W + 1;
  localparam int LO_W    = (DOT_W + 1) / 2;
  localparam int HI_W    = DOT_W - LO_W;
  localparam int Q_W     = 32;
  localparam int NUM_W   = DOT_W + CFG_W + 2;
  localparam int LANES   = 6;
  localparam int ENT_W   = 32;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(65536);
  localparam logic [ENT_W-1:0] SAT_POS   = {1'b0, {(ENT_W-1){1'b1}}};
  localparam logic [ENT_W-1:0] SAT_NEG   = {1'b1, {(ENT_W-1){1'b0}}};

  // lane k holds dot(n_i, n_j) for pairs 00 01 02 11 12 22
  localparam int PAIR_I [LANES] = '{0, 0, 0, 1, 1, 2};
  localparam int PAIR_J [LANES] = '{0, 1, 2, 1, 2, 2};

  typedef struct packed {
    logic             deg;
    logic [LANES-1:0] neg;
  } side_t;

endpackage

// ----- src/triangle_stiffness_matrix.sv -----
// throughput: one triangle per cycle unless the output stalls; six
// normal/product stages, a 33-stage restoring divider (one quotient bit per
// stage, six lanes), one output stage
// a stalled output freezes the whole pipeline; nothing is dropped or repeated
// reset: asynchronous active low, clears valid bits, conductivity to 1.0
module triangle_stiffness_matrix (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                conductivity_we_i,
  input  logic        [tsm_pkg::CFG_W-1:0]    conductivity_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [tsm_pkg::COORD_W-1:0]  corner0_x_i,
  input  logic signed [tsm_pkg::COORD_W-1:0]  corner0_y_i,
  input  logic signed [tsm_pkg::COORD_W-1:0]  corner1_x_i,
  input  logic signed [tsm_pkg::COORD_W-1:0]  corner1_y_i,
  input  logic signed [tsm_pkg::COORD_W-1:0]  corner2_x_i,
  input  logic signed [tsm_pkg::COORD_W-1:0]  corner2_y_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [tsm_pkg::ENT_W-1:0]    entry_00_o,
  output logic signed [tsm_pkg::ENT_W-1:0]    entry_01_o,
  output logic signed [tsm_pkg::ENT_W-1:0]    entry_02_o,
  output logic signed [tsm_pkg::ENT_W-1:0]    entry_10_o,
  output logic signed [tsm_pkg::ENT_W-1:0]    entry_11_o,
  output logic signed [tsm_pkg::ENT_W-1:0]    entry_12_o,
  output logic signed [tsm_pkg::ENT_W-1:0]    entry_20_o,
  output logic signed [tsm_pkg::ENT_W-1:0]    entry_21_o,
  output logic signed [tsm_pkg::ENT_W-1:0]    entry_22_o,
  output logic                                degenerate_o
);

  localparam int L = tsm_pkg::LANES;
  localparam int E = tsm_pkg::ENT_W;

  logic [tsm_pkg::CFG_W-1:0] cond_q;
  logic                      en;
  logic                      out_vld_q;

  logic signed [tsm_pkg::COORD_W-1:0] cx [3], cy [3];

  logic                      f_vld;
  logic [tsm_pkg::NUM_W-1:0] f_num [L];
  logic [tsm_pkg::DEN_W-1:0] f_den;
  tsm_pkg::side_t            f_side;

  logic                      q_vld;
  logic [tsm_pkg::Q_W:0]     q_quo [L];
  tsm_pkg::side_t            q_side;

  logic [E-1:0] ent_d [L], ent_q [L];
  logic         deg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cond_q <= tsm_pkg::CFG_RESET;
    end else if (conductivity_we_i) begin
      cond_q <= conductivity_i;
    end
  end

  assign en         = !out_vld_q || out_ready_i;
  assign in_ready_o = en;

  assign cx[0] = corner0_x_i;
  assign cx[1] = corner1_x_i;
  assign cx[2] = corner2_x_i;
  assign cy[0] = corner0_y_i;
  assign cy[1] = corner1_y_i;
  assign cy[2] = corner2_y_i;

  tsm_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .cx_i    (cx),
    .cy_i    (cy),
    .cond_i  (cond_q),
    .valid_o (f_vld),
    .num_o   (f_num),
    .den_o   (f_den),
    .side_o  (f_side)
  );

  tsm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f_vld),
    .num_i   (f_num),
    .den_i   (f_den),
    .side_i  (f_side),
    .valid_o (q_vld),
    .quo_o   (q_quo),
    .side_o  (q_side)
  );

  // sign, saturation and zero-area forcing
  always_comb begin
    for (int k = 0; k < L; k++) begin
      if (q_side.deg) begin
        ent_d[k] = '0;
      end else if (!q_side.neg[k]) begin
        ent_d[k] = (q_quo[k] > (tsm_pkg::Q_W+1)'(tsm_pkg::SAT_POS))
                   ? tsm_pkg::SAT_POS : E'(q_quo[k]);
      end else begin
        ent_d[k] = (q_quo[k] > (tsm_pkg::Q_W+1)'(tsm_pkg::SAT_NEG))
                   ? tsm_pkg::SAT_NEG : E'(-q_quo[k]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= q_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ent_q <= ent_d;
      deg_q <= q_side.deg;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign entry_00_o   = ent_q[0];
  assign entry_01_o   = ent_q[1];
  assign entry_02_o   = ent_q[2];
  assign entry_10_o   = ent_q[1];
  assign entry_11_o   = ent_q[3];
  assign entry_12_o   = ent_q[4];
  assign entry_20_o   = ent_q[2];
  assign entry_21_o   = ent_q[4];
  assign entry_22_o   = ent_q[5];
  assign degenerate_o = deg_q;

  a_deg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_o |-> entry_00_o == '0 && entry_12_o == '0
                                     && entry_22_o == '0)
    else $error("degenerate beat with nonzero entries");

  a_diag_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(entry_00_o < 0 && entry_11_o > 0)
                    && !(entry_00_o > 0 && entry_11_o < 0))
    else $error("diagonal entries of opposite sign");

  a_no_accept_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(entry_22_o))
    else $error("stalled result lost");

endmodule

// ----- src/tsm_front.sv -----
module tsm_front (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    en_i,
  input  logic                                    valid_i,
  input  logic signed [tsm_pkg::COORD_W-1:0]      cx_i [3],
  input  logic signed [tsm_pkg::COORD_W-1:0]      cy_i [3],
  input  logic        [tsm_pkg::CFG_W-1:0]        cond_i,
  output logic                                    valid_o,
  output logic        [tsm_pkg::NUM_W-1:0]        num_o [tsm_pkg::LANES],
  output logic        [tsm_pkg::DEN_W-1:0]        den_o,
  output tsm_pkg::side_t                          side_o
);

  localparam int DW = tsm_pkg::DIFF_W;
  localparam int PW = tsm_pkg::PROD_W;
  localparam int TW = tsm_pkg::DOT_W;
  localparam int L  = tsm_pkg::LANES;

  logic [5:0] vld_q;

  // stage 1: edge normals
  logic signed [DW-1:0] nx_d [3], ny_d [3], nx_q [3], ny_q [3];

  always_comb begin
    nx_d[0] = DW'(cy_i[1]) - DW'(cy_i[2]);
    ny_d[0] = DW'(cx_i[2]) - DW'(cx_i[1]);
    nx_d[1] = DW'(cy_i[2]) - DW'(cy_i[0]);
    ny_d[1] = DW'(cx_i[0]) - DW'(cx_i[2]);
    nx_d[2] = DW'(cy_i[0]) - DW'(cy_i[1]);
    ny_d[2] = DW'(cx_i[1]) - DW'(cx_i[0]);
  end

  // stage 2: products
  logic signed [PW-1:0] pa_q, pb_q, pxx_q [L], pyy_q [L];

  // stage 3: area and dot products
  logic signed [TW-1:0] d_q, dot_q [L];

  // stage 4: magnitudes
  logic [TW-1:0]            dmag_q, mag_q [L];
  logic [tsm_pkg::DEN_W-1:0] den4_q;
  tsm_pkg::side_t           side4_q;
  logic [L-1:0]             neg4_d;

  // stage 5: partial products of magnitude and conductivity
  logic [tsm_pkg::LO_W+tsm_pkg::CFG_W-1:0] plo_q [L];
  logic [tsm_pkg::HI_W+tsm_pkg::CFG_W-1:0] phi_q [L];
  logic [TW-1:0]             dmag5_q;
  logic [tsm_pkg::DEN_W-1:0] den5_q;
  tsm_pkg::side_t            side5_q;

  // stage 6: rounded numerator
  logic [tsm_pkg::NUM_W-1:0] num_q [L];
  logic [tsm_pkg::DEN_W-1:0] den6_q;
  tsm_pkg::side_t            side6_q;

  always_comb begin
    for (int k = 0; k < L; k++) begin
      neg4_d[k] = dot_q[k][TW-1] ^ d_q[TW-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[4:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        nx_q[k] <= nx_d[k];
        ny_q[k] <= ny_d[k];
      end

      pa_q <= PW'(ny_q[2]) * PW'(nx_q[1]);
      pb_q <= PW'(ny_q[1]) * PW'(nx_q[2]);
      for (int k = 0; k < L; k++) begin
        pxx_q[k] <= PW'(nx_q[tsm_pkg::PAIR_I[k]]) * PW'(nx_q[tsm_pkg::PAIR_J[k]]);
        pyy_q[k] <= PW'(ny_q[tsm_pkg::PAIR_I[k]]) * PW'(ny_q[tsm_pkg::PAIR_J[k]]);
      end

      d_q <= TW'(pa_q) - TW'(pb_q);
      for (int k = 0; k < L; k++) begin
        dot_q[k] <= TW'(pxx_q[k]) + TW'(pyy_q[k]);
      end

      dmag_q  <= d_q[TW-1] ? TW'(-d_q) : TW'(d_q);
      den4_q  <= d_q[TW-1] ? {TW'(-d_q), 1'b0} : {TW'(d_q), 1'b0};
      side4_q <= {(d_q == '0), neg4_d};
      for (int k = 0; k < L; k++) begin
        mag_q[k] <= dot_q[k][TW-1] ? TW'(-dot_q[k]) : TW'(dot_q[k]);
      end

      for (int k = 0; k < L; k++) begin
        plo_q[k] <= (tsm_pkg::LO_W+tsm_pkg::CFG_W)'(mag_q[k][tsm_pkg::LO_W-1:0])
                    * (tsm_pkg::LO_W+tsm_pkg::CFG_W)'(cond_i);
        phi_q[k] <= (tsm_pkg::HI_W+tsm_pkg::CFG_W)'(mag_q[k][TW-1:tsm_pkg::LO_W])
                    * (tsm_pkg::HI_W+tsm_pkg::CFG_W)'(cond_i);
      end
      dmag5_q <= dmag_q;
      den5_q  <= den4_q;
      side5_q <= side4_q;

      for (int k = 0; k < L; k++) begin
        num_q[k] <= tsm_pkg::NUM_W'(plo_q[k])
                    + (tsm_pkg::NUM_W'(phi_q[k]) << tsm_pkg::LO_W)
                    + tsm_pkg::NUM_W'(dmag5_q);
      end
      den6_q  <= den5_q;
      side6_q <= side5_q;
    end
  end

  assign valid_o = vld_q[5];
  assign num_o   = num_q;
  assign den_o   = den6_q;
  assign side_o  = side6_q;

endmodule

// ----- src/tsm_div.sv -----
module tsm_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               valid_i,
  input  logic [tsm_pkg::NUM_W-1:0]          num_i [tsm_pkg::LANES],
  input  logic [tsm_pkg::DEN_W-1:0]          den_i,
  input  tsm_pkg::side_t                     side_i,
  output logic                               valid_o,
  output logic [tsm_pkg::Q_W:0]              quo_o [tsm_pkg::LANES],
  output tsm_pkg::side_t                     side_o
);

  localparam int S = tsm_pkg::Q_W + 1;
  localparam int L = tsm_pkg::LANES;
  localparam int N = tsm_pkg::NUM_W;

  logic [N-1:0]              rem_q [S][L];
  logic [tsm_pkg::Q_W:0]     quo_q [S][L];
  logic [tsm_pkg::DEN_W-1:0] den_q [S];
  tsm_pkg::side_t            side_q [S];
  logic [S-1:0]              vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[S-2:0], valid_i};
    end
  end

  // stage s settles quotient bit Q_W-s; the top bit flags overflow
  for (genvar s = 0; s < S; s++) begin : g_stage
    logic [N-1:0]              rem_in [L];
    logic [tsm_pkg::Q_W:0]     quo_in [L];
    logic [tsm_pkg::DEN_W-1:0] den_in;
    tsm_pkg::side_t            side_in;
    logic [N-1:0]              dvs;

    if (s == 0) begin : g_first
      always_comb begin
        for (int k = 0; k < L; k++) begin
          rem_in[k] = num_i[k];
          quo_in[k] = '0;
        end
        den_in  = den_i;
        side_in = side_i;
      end
    end else begin : g_next
      always_comb begin
        for (int k = 0; k < L; k++) begin
          rem_in[k] = rem_q[s-1][k];
          quo_in[k] = quo_q[s-1][k];
        end
        den_in  = den_q[s-1];
        side_in = side_q[s-1];
      end
    end

    assign dvs = N'(den_in) << (tsm_pkg::Q_W - s);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int k = 0; k < L; k++) begin
          if (rem_in[k] >= dvs) begin
            rem_q[s][k] <= rem_in[k] - dvs;
            quo_q[s][k] <= quo_in[k]
                           | ((tsm_pkg::Q_W+1)'(1) << (tsm_pkg::Q_W - s));
          end else begin
            rem_q[s][k] <= rem_in[k];
            quo_q[s][k] <= quo_in[k];
          end
        end
        den_q[s]  <= den_in;
        side_q[s] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[S-1];
  assign quo_o   = quo_q[S-1];
  assign side_o  = side_q[S-1];

endmodule

// ----- sim/tsm_checker.sv -----
`timescale 1ns / 100ps

module tsm_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                conductivity_we_i,
  input  logic        [tsm_pkg::CFG_W-1:0]    conductivity_i,
  input  logic                                in_valid_i,
  input  logic                                in_ready_i,
  input  logic signed [tsm_pkg::COORD_W-1:0]  corner0_x_i,
  input  logic signed [tsm_pkg::COORD_W-1:0]  corner0_y_i,
  input  logic signed [tsm_pkg::COORD_W-1:0]  corner1_x_i,
  input  logic signed [tsm_pkg::COORD_W-1:0]  corner1_y_i,
  input  logic signed [tsm_pkg::COORD_W-1:0]  corner2_x_i,
  input  logic signed [tsm_pkg::COORD_W-1:0]  corner2_y_i,
  input  logic                                out_valid_i,
  input  logic                                out_ready_i,
  input  logic signed [tsm_pkg::ENT_W-1:0]    entry_00_i,
  input  logic signed [tsm_pkg::ENT_W-1:0]    entry_01_i,
  input  logic signed [tsm_pkg::ENT_W-1:0]    entry_02_i,
  input  logic signed [tsm_pkg::ENT_W-1:0]    entry_10_i,
  input  logic signed [tsm_pkg::ENT_W-1:0]    entry_11_i,
  input  logic signed [tsm_pkg::ENT_W-1:0]    entry_12_i,
  input  logic signed [tsm_pkg::ENT_W-1:0]    entry_20_i,
  input  logic signed [tsm_pkg::ENT_W-1:0]    entry_21_i,
  input  logic signed [tsm_pkg::ENT_W-1:0]    entry_22_i,
  input  logic                                degenerate_i,
  output int                                  errors_o,
  output int                                  pending_o,
  output int                                  matrices_o,
  output int                                  degenerates_o
);

  typedef struct {
    logic [tsm_pkg::ENT_W-1:0] entry [9];
    logic                      deg;
  } element_matrix_t;

  logic [tsm_pkg::CFG_W-1:0] cond_q;
  element_matrix_t           matrix_q [$];

  function automatic element_matrix_t conduction_matrix(
      input longint signed x0, input longint signed y0,
      input longint signed x1, input longint signed y1,
      input longint signed x2, input longint signed y2,
      input logic [31:0] cond);
    element_matrix_t  m;
    longint signed    nx [3];
    longint signed    ny [3];
    longint signed    area2;
    longint signed    dot;
    logic [127:0]     amag;
    logic [127:0]     dmag;
    logic [127:0]     q;
    logic             neg;
    nx[0] = y1 - y2; ny[0] = x2 - x1;
    nx[1] = y2 - y0; ny[1] = x0 - x2;
    nx[2] = y0 - y1; ny[2] = x1 - x0;
    area2 = ny[2] * nx[1] - ny[1] * nx[2];
    m.deg = (area2 == 0);
    amag = (area2 < 0) ? 128'(-area2) : 128'(area2);
    for (int k = 0; k < 9; k++) begin
      m.entry[k] = '0;
      if (!m.deg) begin
        dot  = nx[k/3] * nx[k%3] + ny[k/3] * ny[k%3];
        neg  = (dot < 0) != (area2 < 0);
        dmag = (dot < 0) ? 128'(-dot) : 128'(dot);
        q    = (dmag * 128'(cond) + amag) / (amag << 1);
        if (!neg) m.entry[k] = (q > 128'h7FFFFFFF) ? tsm_pkg::SAT_POS : q[31:0];
        else if (q > 128'h80000000) m.entry[k] = tsm_pkg::SAT_NEG;
        else m.entry[k] = 32'(-q[31:0]);
      end
    end
    return m;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
    errors_o++;
  endtask

  initial begin
    errors_o = 0; matrices_o = 0; degenerates_o = 0;
  end

  assign pending_o = matrix_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cond_q <= tsm_pkg::CFG_RESET;
    end else if (conductivity_we_i) begin
      cond_q <= conductivity_i;
    end
  end

  always @(posedge clk_i) begin
    element_matrix_t want;
    logic [31:0]     got [9];
    if (rst_ni && in_valid_i && in_ready_i) begin
      matrix_q.push_back(conduction_matrix(corner0_x_i, corner0_y_i, corner1_x_i,
                                           corner1_y_i, corner2_x_i, corner2_y_i, cond_q));
    end
    if (rst_ni && out_valid_i && out_ready_i) begin
      matrices_o++;
      if (matrix_q.size() == 0) begin
        report("unexpected beat", {31'b0, degenerate_i}, 32'b0);
      end else begin
        want = matrix_q.pop_front();
        got = '{entry_00_i, entry_01_i, entry_02_i, entry_10_i, entry_11_i,
                entry_12_i, entry_20_i, entry_21_i, entry_22_i};
        if (degenerate_i) degenerates_o++;
        if (degenerate_i !== want.deg) report("degenerate", {31'b0, degenerate_i}, {31'b0, want.deg});
        for (int k = 0; k < 9; k++) begin
          if (got[k] !== want.entry[k])
            report($sformatf("entry_%0d%0d", k/3, k%3), got[k], want.entry[k]);
        end
      end
    end
  end

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

  localparam int CW    = tsm_pkg::COORD_W;
  localparam int LIMIT = 500000;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       conductivity_we_i = 1'b0;
  logic [tsm_pkg::CFG_W-1:0]  conductivity_i = '0;
  logic                       in_valid_i = 1'b0;
  logic                       in_ready_o;
  logic signed [CW-1:0]       corner [6] = '{default: '0};
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b0;
  logic signed [tsm_pkg::ENT_W-1:0] entry [9];
  logic                       degenerate_o;
  int                         errors, pending, matrices, degenerates;
  int                         cycles = 0;
  int                         sent = 0;
  bit                         burst = 1'b0;
  bit                         hold_done = 1'b0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  triangle_stiffness_matrix i_dut (
    .clk_i, .rst_ni, .conductivity_we_i, .conductivity_i, .in_valid_i, .in_ready_o,
    .corner0_x_i(corner[0]), .corner0_y_i(corner[1]), .corner1_x_i(corner[2]),
    .corner1_y_i(corner[3]), .corner2_x_i(corner[4]), .corner2_y_i(corner[5]),
    .out_valid_o, .out_ready_i,
    .entry_00_o(entry[0]), .entry_01_o(entry[1]), .entry_02_o(entry[2]),
    .entry_10_o(entry[3]), .entry_11_o(entry[4]), .entry_12_o(entry[5]),
    .entry_20_o(entry[6]), .entry_21_o(entry[7]), .entry_22_o(entry[8]),
    .degenerate_o
  );

  tsm_checker i_checker (
    .clk_i, .rst_ni, .conductivity_we_i, .conductivity_i, .in_valid_i,
    .in_ready_i(in_ready_o),
    .corner0_x_i(corner[0]), .corner0_y_i(corner[1]), .corner1_x_i(corner[2]),
    .corner1_y_i(corner[3]), .corner2_x_i(corner[4]), .corner2_y_i(corner[5]),
    .out_valid_i(out_valid_o), .out_ready_i,
    .entry_00_i(entry[0]), .entry_01_i(entry[1]), .entry_02_i(entry[2]),
    .entry_10_i(entry[3]), .entry_11_i(entry[4]), .entry_12_i(entry[5]),
    .entry_20_i(entry[6]), .entry_21_i(entry[7]), .entry_22_i(entry[8]),
    .degenerate_i(degenerate_o),
    .errors_o(errors), .pending_o(pending), .matrices_o(matrices),
    .degenerates_o(degenerates)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver: random stalls, one long hold-off once more than 300 triangles are sent
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      stall = burst ? 0 : $urandom_range(0, 12);
      if (!hold_done && sent > 300) begin
        stall = 400;
        hold_done = 1'b1;
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  task automatic send_triangle(input logic [CW-1:0] c [6]);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    for (int k = 0; k < 6; k++) corner[k] <= c[k];
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    sent++;
  endtask

  task automatic set_conductivity(input logic [31:0] value);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    conductivity_we_i <= 1'b1;
    conductivity_i    <= value;
    @(posedge clk_i);
    conductivity_we_i <= 1'b0;
  endtask

  function automatic logic [CW-1:0] rand_coord(input int mode);
    case (mode)
      0: return CW'($urandom);
      1: return CW'($signed($urandom_range(0, 2047)) - 1024);
      default: return CW'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
    endcase
  endfunction

  task automatic random_triangles(input int count);
    logic [CW-1:0] c [6];
    int            mode, kind;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 29) == 0) burst = !burst;
      mode = $urandom_range(0, 2);
      for (int k = 0; k < 6; k++) c[k] = rand_coord(mode);
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        c[2] = c[0]; c[4] = c[0];
      end else if (kind == 1) begin
        c[4] = c[0]; c[5] = c[1];
      end else if (kind == 2) begin
        c[3] = c[1]; c[5] = c[1];
      end
      send_triangle(c);
    end
    burst = 1'b0;
  endtask

  localparam logic [CW-1:0] MAXC = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] MINC = {1'b1, {(CW-1){1'b0}}};
  localparam logic [CW-1:0] ONE  = CW'(1 << 16);

  initial begin
    logic [CW-1:0] d [6];
    logic [31:0]   settings [5];
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: unit triangles both windings, extremes, zero area, slivers
    d = '{0, 0, ONE, 0, 0, ONE};          send_triangle(d);
    d = '{0, 0, 0, ONE, ONE, 0};          send_triangle(d);
    d = '{MINC, MINC, MAXC, MINC, MINC, MAXC}; send_triangle(d);
    d = '{MAXC, MAXC, MINC, MAXC, MAXC, MINC}; send_triangle(d);
    d = '{MINC, MINC, MAXC, MAXC, MINC, MAXC}; send_triangle(d);
    d = '{MAXC, MINC, MINC, MAXC, MAXC, MAXC}; send_triangle(d);
    d = '{0, 0, 0, 0, 0, 0};              send_triangle(d);
    d = '{MAXC, MAXC, MAXC, MAXC, MAXC, MAXC}; send_triangle(d);
    d = '{MINC, MINC, 0, 0, MAXC, MAXC};  send_triangle(d);
    d = '{0, 0, 1, 0, 0, 1};              send_triangle(d);
    d = '{0, 0, MAXC, 0, 0, 1};           send_triangle(d);
    d = '{MINC, 0, MAXC, 0, 0, 1};        send_triangle(d);
    d = '{0, MINC, 0, MAXC, 1, 0};        send_triangle(d);
    d = '{5, 7, 5, 7, 100, 3};            send_triangle(d);
    d = '{-1, -1, 1, -1, 0, 1};           send_triangle(d);

    settings = '{32'hFFFF_FFFF, 32'h0, 32'h1, $urandom, tsm_pkg::CFG_RESET};
    foreach (settings[s]) begin
      set_conductivity(settings[s]);
      d = '{MINC, MINC, MAXC, MINC, MINC, MAXC}; send_triangle(d);
      d = '{0, 0, MAXC, 0, 0, 1};          send_triangle(d);
      random_triangles(170);
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    $display("covered %0d triangles (%0d with zero area) over 6 conductivity settings",
             matrices, degenerates);
    $display("extreme corners, both windings, slivers and a long output stall included");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
